// File: design/ksl_pkg.sv
package ksl_pkg;

    localparam int ENTRIES_DEFAULT    = 256;
    localparam int KEY_WIDTH_DEFAULT  = 64;
    localparam int TURN_WIDTH_DEFAULT = 31;

    typedef enum logic [1:0] {
        CMD_LOOKUP  = 2'd0,
        CMD_RECORD  = 2'd1,
        CMD_ADVANCE = 2'd2,
        CMD_CLEAR   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_DONE
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic write_entry;
        logic advance;
        logic clear;
        logic result_load;
    } ctrl_t;

    // Datapath to controller.
    typedef struct packed {
        logic scan_last;
        logic found;
    } stat_t;

endpackage

// File: design/ksl_ram.sv
module ksl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/ksl_datapath.sv
module ksl_datapath #(
    parameter int ENTRIES    = ksl_pkg::ENTRIES_DEFAULT,
    parameter int KEY_WIDTH  = ksl_pkg::KEY_WIDTH_DEFAULT,
    parameter int TURN_WIDTH = ksl_pkg::TURN_WIDTH_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ksl_pkg::ctrl_t       ctrl,
    output ksl_pkg::stat_t       stat,
    output ksl_pkg::cmd_t        cmd_q,
    input  logic [1:0]           command,
    input  logic [63:0]          source_key,
    input  logic [63:0]          item_key,
    input  logic [31:0]          score_bits,
    output logic                 hit,
    output logic [30:0]          first_turn,
    output logic [30:0]          last_turn,
    output logic [31:0]          stored_score,
    output logic [30:0]          turn_value,
    output logic                 evicted
);

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [TURN_WIDTH-1:0] TURN_MAX = {TURN_WIDTH{1'b1}};
    localparam logic [CW-1:0] FULL = CW'(ENTRIES);

    ksl_pkg::cmd_t         cmd_reg;
    logic [KEY_WIDTH-1:0]  sk_reg;
    logic [KEY_WIDTH-1:0]  ik_reg;
    logic [31:0]           score_reg;
    logic [CW-1:0]         count_reg;
    logic [TURN_WIDTH-1:0] turn_reg;
    logic [CW-1:0]         idx_reg;      // address issued to the RAMs
    logic                  chk_reg;      // read data of previous address valid
    logic [AW-1:0]         chk_idx_reg;
    logic                  found_reg;
    logic [AW-1:0]         found_idx_reg;
    logic [TURN_WIDTH-1:0] found_ft_reg;
    logic [TURN_WIDTH-1:0] found_lt_reg;
    logic [31:0]           found_sc_reg;
    logic [AW-1:0]         old_idx_reg;
    logic [TURN_WIDTH-1:0] old_lt_reg;

    logic [KEY_WIDTH-1:0]  rd_sk;
    logic [KEY_WIDTH-1:0]  rd_ik;
    logic [TURN_WIDTH-1:0] rd_ft;
    logic [TURN_WIDTH-1:0] rd_lt;
    logic [31:0]           rd_sc;

    logic                  we;
    logic [AW-1:0]         waddr;
    logic                  new_entry;
    logic                  match;
    logic [AW-1:0]         raddr;

    assign cmd_q     = cmd_reg;
    assign match     = chk_reg && (rd_sk == sk_reg) && (rd_ik == ik_reg);
    assign raddr     = idx_reg[AW-1:0];
    assign new_entry = !found_reg;
    assign we        = ctrl.write_entry;
    assign waddr     = found_reg ? found_idx_reg
                     : (count_reg < FULL) ? count_reg[AW-1:0] : old_idx_reg;

    assign stat.scan_last  = !chk_reg && (idx_reg >= count_reg);
    assign stat.found      = found_reg;

    ksl_ram #(.WIDTH(KEY_WIDTH), .DEPTH(ENTRIES)) u_sk (
        .clk(clk), .we(we && new_entry), .waddr(waddr), .wdata(sk_reg),
        .raddr(raddr), .rdata(rd_sk));
    ksl_ram #(.WIDTH(KEY_WIDTH), .DEPTH(ENTRIES)) u_ik (
        .clk(clk), .we(we && new_entry), .waddr(waddr), .wdata(ik_reg),
        .raddr(raddr), .rdata(rd_ik));
    ksl_ram #(.WIDTH(TURN_WIDTH), .DEPTH(ENTRIES)) u_ft (
        .clk(clk), .we(we && new_entry), .waddr(waddr), .wdata(turn_reg),
        .raddr(raddr), .rdata(rd_ft));
    ksl_ram #(.WIDTH(TURN_WIDTH), .DEPTH(ENTRIES)) u_lt (
        .clk(clk), .we(we), .waddr(waddr), .wdata(turn_reg),
        .raddr(raddr), .rdata(rd_lt));
    ksl_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_sc (
        .clk(clk), .we(we), .waddr(waddr), .wdata(score_reg),
        .raddr(raddr), .rdata(rd_sc));

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg   <= ksl_pkg::cmd_t'(command);
            sk_reg    <= source_key[KEY_WIDTH-1:0];
            ik_reg    <= item_key[KEY_WIDTH-1:0];
            score_reg <= score_bits;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            turn_reg  <= '0;
            idx_reg   <= '0;
            chk_reg   <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.scan_start)
            begin
                idx_reg   <= '0;
                chk_reg   <= 1'b0;
                found_reg <= 1'b0;
            end
            else if (ctrl.scan_step)
            begin
                // One address issued per cycle; its data is compared next cycle.
                chk_reg     <= (idx_reg < count_reg);
                chk_idx_reg <= idx_reg[AW-1:0];
                if (idx_reg < count_reg)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                if (match && !found_reg)
                begin
                    found_reg     <= 1'b1;
                    found_idx_reg <= chk_idx_reg;
                    found_ft_reg  <= rd_ft;
                    found_lt_reg  <= rd_lt;
                    found_sc_reg  <= rd_sc;
                end
                if (chk_reg && (chk_idx_reg == '0 || rd_lt < old_lt_reg))
                begin
                    old_idx_reg <= chk_idx_reg;
                    old_lt_reg  <= rd_lt;
                end
            end
            if (ctrl.write_entry && new_entry && count_reg < FULL)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (ctrl.advance)
            begin
                turn_reg <= (turn_reg >= TURN_MAX) ? TURN_WIDTH'(1) : turn_reg + 1'b1;
            end
            if (ctrl.clear)
            begin
                count_reg <= '0;
                turn_reg  <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.result_load)
        begin
            hit          <= 1'b0;
            first_turn   <= '0;
            last_turn    <= '0;
            stored_score <= '0;
            turn_value   <= '0;
            evicted      <= 1'b0;
            case (cmd_reg)
                ksl_pkg::CMD_LOOKUP:
                begin
                    hit <= found_reg;
                    if (found_reg)
                    begin
                        first_turn   <= 31'(found_ft_reg);
                        last_turn    <= 31'(found_lt_reg);
                        stored_score <= found_sc_reg;
                    end
                end
                ksl_pkg::CMD_RECORD:
                begin
                    hit     <= found_reg;
                    evicted <= !found_reg && (count_reg == FULL);
                end
                ksl_pkg::CMD_ADVANCE:
                begin
                    turn_value <= 31'(turn_reg);
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

// File: design/ksl_ctrl.sv
module ksl_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  ksl_pkg::cmd_t  cmd_q,
    input  ksl_pkg::stat_t stat,
    output ksl_pkg::ctrl_t ctrl
);

    ksl_pkg::state_t state_reg;
    ksl_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ksl_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ctrl           = '0;
        in_ready       = 1'b0;
        case (state_reg)
            ksl_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.load       = 1'b1;
                    ctrl.scan_start = 1'b1;
                    state_next      = ksl_pkg::ST_SCAN;
                end
            end
            ksl_pkg::ST_SCAN:
            begin
                if (cmd_q == ksl_pkg::CMD_ADVANCE)
                begin
                    ctrl.advance = 1'b1;
                    state_next   = ksl_pkg::ST_DONE;
                end
                else if (cmd_q == ksl_pkg::CMD_CLEAR)
                begin
                    ctrl.clear = 1'b1;
                    state_next = ksl_pkg::ST_DONE;
                end
                else if (stat.scan_last)
                begin
                    state_next = (cmd_q == ksl_pkg::CMD_RECORD) ? ksl_pkg::ST_WRITE
                                                                : ksl_pkg::ST_DONE;
                end
                else
                begin
                    ctrl.scan_step = 1'b1;
                end
            end
            ksl_pkg::ST_WRITE:
            begin
                // The result of a record is captured with the table write, so both wait
                // until the previous result beat has left the output register.
                if (!out_valid_reg || out_ready)
                begin
                    ctrl.result_load = 1'b1;
                    ctrl.write_entry = 1'b1;
                    out_valid_next   = 1'b1;
                    state_next       = ksl_pkg::ST_IDLE;
                end
            end
            ksl_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    ctrl.result_load = 1'b1;
                    out_valid_next   = 1'b1;
                    state_next       = ksl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ksl_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.write_entry |=> !ctrl.write_entry)
        else $error("table written twice for one command");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ksl_pkg::ST_IDLE) |-> !in_ready)
        else $error("input accepted while busy");
    a_write_record: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.write_entry |-> (cmd_q == ksl_pkg::CMD_RECORD))
        else $error("table write outside record");
`endif

endmodule

// File: design/keyed_set_with_lru_eviction.sv
// Fully associative key-pair table with least-recently-recorded eviction. Each command is
// one beat in and one beat out. Lookup and record scan the occupied entries one per cycle
// through the RAM read port; advance and clear skip the scan. The next command is taken
// once the result has been registered; the result may wait on the output while the block
// stays ready.
module keyed_set_with_lru_eviction #(
    parameter int ENTRIES    = ksl_pkg::ENTRIES_DEFAULT,
    parameter int KEY_WIDTH  = ksl_pkg::KEY_WIDTH_DEFAULT,
    parameter int TURN_WIDTH = ksl_pkg::TURN_WIDTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [63:0] source_key,
    input  logic [63:0] item_key,
    input  logic [31:0] score_bits,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        hit,
    output logic [30:0] first_turn,
    output logic [30:0] last_turn,
    output logic [31:0] stored_score,
    output logic [30:0] turn_value,
    output logic        evicted
);

    ksl_pkg::ctrl_t ctrl;
    ksl_pkg::stat_t stat;
    ksl_pkg::cmd_t  cmd_q;

    ksl_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .cmd_q(cmd_q),
        .stat(stat), .ctrl(ctrl));

    ksl_datapath #(
        .ENTRIES(ENTRIES), .KEY_WIDTH(KEY_WIDTH), .TURN_WIDTH(TURN_WIDTH)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .stat(stat), .cmd_q(cmd_q),
        .command(command), .source_key(source_key), .item_key(item_key),
        .score_bits(score_bits), .hit(hit), .first_turn(first_turn),
        .last_turn(last_turn), .stored_score(stored_score),
        .turn_value(turn_value), .evicted(evicted));

endmodule
